// ----- rtl/gpam_pkg.sv -----
// Shared types and constants for the growable page allocation map.
`timescale 1ns / 1ps

package gpam_pkg;

  localparam int MAX_PAGES_DEF = 64;
  localparam int PAGE_W        = 6;
  localparam int PAGE_SPAN     = 1 << PAGE_W;
  localparam int PROT_W        = 7;
  localparam int STATUS_W      = 2;
  localparam logic [PROT_W-1:0] PROT_RESET = 7'd2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    status_t           status;
    logic              grew;
  } rsp_t;

endpackage

// ----- rtl/growable_page_allocation_map_core.sv -----
// Top level of the growable page allocation map: input and result registers around the core.
//
//   channel | ports                                          | direction
//   in      | in_valid, in_stall, in_cmd, in_page_index      | request word in
//   out     | out_valid, out_stall, out_granted_page,        | result word out
//           | out_status, out_grew                           |
//   cfg     | cfg_we, cfg_wdata                              | protected page limit
//
// One word per cycle while the result is not stalled; a taken request passes
// through the input register, then the bitmap search into the result register.
// The first-fit search over the flip-flop bitmap sets the cycle time.
// Synchronous reset clears the bitmap and page count; the limit returns to 2.
// A stalled result holds; the input register fills behind it, then in_stall rises.
`timescale 1ns / 1ps

module growable_page_allocation_map_core #(
  parameter int MAX_PAGES = gpam_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [gpam_pkg::PAGE_W-1:0]   in_page_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpam_pkg::PAGE_W-1:0]   out_granted_page,
  output logic [gpam_pkg::STATUS_W-1:0] out_status,
  output logic                          out_grew,
  input  logic                          cfg_we,
  input  logic [gpam_pkg::PROT_W-1:0]   cfg_wdata
);

  logic           req_valid_r;
  gpam_pkg::req_t req_r;
  logic           out_valid_r;
  gpam_pkg::rsp_t rsp_r;
  gpam_pkg::rsp_t rsp;
  logic           out_free;
  logic           advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;

  gpam_core #(
    .MAX_PAGES(MAX_PAGES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (advance),
    .req       (req_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= req_valid_r;
      end
    end
  end

  // Capture a new word whenever the input register is not held; load the result on advance.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r.cmd        <= gpam_pkg::cmd_t'(in_cmd);
      req_r.page_index <= in_page_index;
    end
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = rsp_r.granted_page;
  assign out_status       = rsp_r.status;
  assign out_grew         = rsp_r.grew;

endmodule

// ----- rtl/gpam_core.sv -----
// Page bitmap, page count and first-fit search for one request per cycle.
`timescale 1ns / 1ps

module gpam_core #(
  parameter int MAX_PAGES = gpam_pkg::MAX_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  gpam_pkg::req_t              req,
  input  logic                        cfg_we,
  input  logic [gpam_pkg::PROT_W-1:0] cfg_wdata,
  output gpam_pkg::rsp_t              rsp
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int CMP_W = (CNT_W > gpam_pkg::PROT_W) ? CNT_W : gpam_pkg::PROT_W;

  logic [MAX_PAGES-1:0]        used_map_r, used_map_nxt;
  logic [CNT_W-1:0]            page_count_r, page_count_nxt;
  logic [gpam_pkg::PROT_W-1:0] prot_r;

  logic [IDX_W-1:0] free_idx;
  logic             found;
  logic             is_free;
  logic             free_ok;
  logic             grow;

  // Lowest clear bit; bits at or above the count are always clear.
  always_comb begin
    free_idx = '0;
    found    = 1'b0;
    for (int j = MAX_PAGES - 1; j >= 0; j--) begin
      if (!used_map_r[j]) begin
        free_idx = IDX_W'(j);
        found    = 1'b1;
      end
    end
  end

  assign is_free = (req.cmd == gpam_pkg::CMD_FREE);
  assign free_ok = is_free
                 && ({1'b0, req.page_index} >= prot_r)
                 && (CMP_W'(req.page_index) < CMP_W'(page_count_r));
  assign grow    = !is_free && found && (CNT_W'(free_idx) == page_count_r);

  always_comb begin
    used_map_nxt   = used_map_r;
    page_count_nxt = page_count_r;
    if (req_valid) begin
      if (is_free) begin
        for (int j = 0; j < MAX_PAGES; j++) begin
          if (free_ok && (j < gpam_pkg::PAGE_SPAN)
              && (req.page_index == gpam_pkg::PAGE_W'(j))) begin
            used_map_nxt[j] = 1'b0;
          end
        end
      end else if (found) begin
        used_map_nxt[free_idx] = 1'b1;
        if (grow) begin
          page_count_nxt = page_count_r + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp.granted_page = '0;
    rsp.grew         = 1'b0;
    rsp.status       = gpam_pkg::STAT_OK;
    if (is_free) begin
      if (!free_ok) begin
        rsp.status = gpam_pkg::STAT_REJECT;
      end
    end else if (found) begin
      rsp.granted_page = gpam_pkg::PAGE_W'(free_idx);
      rsp.grew         = grow;
    end else begin
      rsp.status = gpam_pkg::STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_map_r   <= '0;
      page_count_r <= '0;
      prot_r       <= gpam_pkg::PROT_RESET;
    end else begin
      used_map_r   <= used_map_nxt;
      page_count_r <= page_count_nxt;
      if (cfg_we) begin
        prot_r <= cfg_wdata;
      end
    end
  end

endmodule
